FILE: rtl/dsa_pkg.sv
// Shared constants, types and score quantization for the detection score argsort unit.
`default_nettype none

package dsa_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int SCORE_BITS = 16;
   localparam int CELL_DEPTH = 64;
   localparam int CAPACITY   = (MAX_ITEMS > CELL_DEPTH) ? CELL_DEPTH : MAX_ITEMS;

   localparam int SCORE_W    = 16;
   localparam int LABEL_W    = 10;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int LMK_W      = 4;
   localparam int BASE_W     = 10;

   localparam int DROP_BITS  = (SCORE_BITS >= SCORE_W) ? 0 : (SCORE_W - SCORE_BITS);
   localparam logic [SCORE_W-1:0] SCORE_KEEP_MASK =
      SCORE_W'(~((32'd1 << DROP_BITS) - 32'd1));

   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [LABEL_W-1:0] label;
      logic [INDEX_W-1:0] index;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      drain;
      entry_type new_entry;
   } cell_cmd_type;

   function automatic logic [SCORE_W-1:0] quantize_score(input logic [SCORE_W-1:0] s);
      return s & SCORE_KEEP_MASK;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dsa_cell.sv
// One cell of the sorted chain: holds one detection, inserts or shifts when the command asks for it.
`default_nettype none

module dsa_cell import dsa_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         live,
   input  logic         prev_keep,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   output logic         keep,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // a live cell with a score at least as high stays ahead of the new item
   assign keep  = live && (entry_ff.score >= cmd.new_entry.score);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = cmd.new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.drain) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: rtl/detection_score_argsort_unit.sv
// Top level: load control, cell chain and sorted drain of detections.
// Loading takes one detection per cycle while no list drains; each one that fits is placed into
// the chain in the cycle it transfers. After the last detection transfers, the first result is valid
// in the next cycle; results then leave one per cycle from the head cell while rsp_ready is high.
// No detection is taken while a list drains; a dropped last detection with an empty list gives
// no result. Synchronous reset clears the count, overflow flag, state and landmarks register;
// the cell contents are not cleared.
`default_nettype none

module detection_score_argsort_unit import dsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_wr_en,
   input  logic [LMK_W-1:0]   csr_wr_data,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SCORE_W-1:0] req_score,
   input  logic [LABEL_W-1:0] req_label,
   input  logic               req_is_last,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_orig_index,
   output logic [SCORE_W-1:0] rsp_sorted_score,
   output logic [LABEL_W-1:0] rsp_sorted_label,
   output logic [BASE_W-1:0]  rsp_landmark_base,
   output logic               rsp_overflow,
   output logic               rsp_last_out
);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic               state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               drop_ff, drop_in;
   logic [LMK_W-1:0]   lmk_ff, lmk_in;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               has_room;
   logic [COUNT_W-1:0] count_after;
   cell_cmd_type       cmd;

   entry_type          cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_keep;
   logic [CAPACITY-1:0] cell_live;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign has_room  = (count_ff < CAPACITY_COUNT);
   assign count_after = has_room ? (count_ff + COUNT_W'(1)) : count_ff;

   always_comb begin
      cmd.insert          = req_xfer && has_room;
      cmd.drain           = rsp_xfer;
      cmd.new_entry.score = quantize_score(req_score);
      cmd.new_entry.label = req_label;
      cmd.new_entry.index = count_ff[INDEX_W-1:0];
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic      prev_keep;
         entry_type prev_entry;
         entry_type next_entry;

         assign cell_live[gi] = (count_ff > COUNT_W'(gi));

         if (gi == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = '0;
         end else begin : g_body
            assign prev_keep  = cell_keep[gi-1];
            assign prev_entry = cell_entry[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign next_entry = '0;
         end else begin : g_mid
            assign next_entry = cell_entry[gi+1];
         end

         dsa_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .live       (cell_live[gi]),
            .prev_keep  (prev_keep),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .keep       (cell_keep[gi]),
            .entry      (cell_entry[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      lmk_in   = csr_wr_en ? csr_wr_data : lmk_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               count_in = count_after;
               drop_in  = drop_ff || !has_room;
               if (req_is_last) begin
                  if (count_after == '0) begin
                     // nothing stored: close the list at once
                     drop_in = 1'b0;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer) begin
               if (count_ff == COUNT_W'(1)) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  drop_in  = 1'b0;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         lmk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         lmk_ff   <= lmk_in;
      end
   end

   assign rsp_orig_index    = cell_entry[0].index;
   assign rsp_sorted_score  = cell_entry[0].score;
   assign rsp_sorted_label  = cell_entry[0].label;
   assign rsp_landmark_base = BASE_W'(cell_entry[0].index) * BASE_W'(lmk_ff);
   assign rsp_overflow      = drop_ff;
   assign rsp_last_out      = (count_ff == COUNT_W'(1));

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("drain with empty chain");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY_COUNT)
      else $error("item count beyond capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (count_ff > COUNT_W'(1))) |-> (cell_entry[0].score >= cell_entry[1].score))
      else $error("chain head out of order");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last_out) |=> (req_ready && (count_ff == '0) && !drop_ff))
      else $error("list not closed after last result");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_is_last && (count_after != '0)) |=> rsp_valid)
      else $error("last item did not start the drain");

endmodule

`default_nettype wire

FILE: dv/tb_detection_score_argsort_unit.sv
// Self-checking testbench for the detection score argsort unit: stable descending sort checks.
`timescale 1ns / 1ps

module tb_detection_score_argsort_unit;
   import dsa_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 20;
   localparam int Q_DROP = (SCORE_BITS >= SCORE_W) ? 0 : (SCORE_W - SCORE_BITS);
   localparam logic [SCORE_W-1:0] Q_MASK = {SCORE_W{1'b1}} << Q_DROP;

   typedef struct packed {
      logic [INDEX_W-1:0] orig_index;
      logic [SCORE_W-1:0] score;
      logic [LABEL_W-1:0] label;
      logic [BASE_W-1:0]  base;
      logic               overflow;
      logic               last;
   } ranked_detection_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [LMK_W-1:0]   csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [SCORE_W-1:0] req_score = '0;
   logic [LABEL_W-1:0] req_label = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_orig_index;
   logic [SCORE_W-1:0] rsp_sorted_score;
   logic [LABEL_W-1:0] rsp_sorted_label;
   logic [BASE_W-1:0]  rsp_landmark_base;
   logic               rsp_overflow;
   logic               rsp_last_out;

   // predictor state: the sorted chain as the block should hold it
   logic [SCORE_W-1:0] chain_score [CELL_DEPTH];
   logic [LABEL_W-1:0] chain_label [CELL_DEPTH];
   logic [INDEX_W-1:0] chain_index [CELL_DEPTH];
   int                 chain_count = 0;
   logic               chain_dropped = 1'b0;
   logic [LMK_W-1:0]   lmk_per_item = '0;

   ranked_detection_type ranked_q [$];

   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int lists_sent = 0;
   int results_checked = 0;
   int overflow_lists = 0;
   int csr_writes = 0;
   bit send_idle_en = 1'b0;
   bit rsp_idle_en = 1'b0;
   int hold_off_request = 0;
   int stall_left = 0;

   detection_score_argsort_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_score         (req_score),
      .req_label         (req_label),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_orig_index    (rsp_orig_index),
      .rsp_sorted_score  (rsp_sorted_score),
      .rsp_sorted_label  (rsp_sorted_label),
      .rsp_landmark_base (rsp_landmark_base),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_out      (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still expected",
                  $time, cycle_count, ranked_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Insert one transferred detection into the predicted chain; on the last one,
   // queue the whole chain in rank order and start an empty list.
   task automatic rank_detection(input logic [SCORE_W-1:0] score_in,
                                 input logic [LABEL_W-1:0] label_in, input logic last_in);
      logic [SCORE_W-1:0]   qs;
      int                   pos;
      ranked_detection_type r;
      qs = score_in & Q_MASK;
      if (chain_count < CAPACITY) begin
         pos = chain_count;
         while (pos > 0 && chain_score[pos-1] < qs) begin
            chain_score[pos] = chain_score[pos-1];
            chain_label[pos] = chain_label[pos-1];
            chain_index[pos] = chain_index[pos-1];
            pos--;
         end
         chain_score[pos] = qs;
         chain_label[pos] = label_in;
         chain_index[pos] = INDEX_W'(chain_count);
         chain_count++;
      end else begin
         chain_dropped = 1'b1;
      end
      if (last_in) begin
         if (chain_dropped) overflow_lists++;
         for (int k = 0; k < chain_count; k++) begin
            r.orig_index = chain_index[k];
            r.score      = chain_score[k];
            r.label      = chain_label[k];
            r.base       = BASE_W'(int'(chain_index[k]) * int'(lmk_per_item));
            r.overflow   = chain_dropped;
            r.last       = (k == chain_count - 1);
            ranked_q     = {ranked_q, r};
         end
         chain_count   = 0;
         chain_dropped = 1'b0;
         lists_sent++;
      end
   endtask

   // Offer one detection, hold it until the transfer, then update the predictor.
   task automatic send_detection(input logic [SCORE_W-1:0] score_in,
                                 input logic [LABEL_W-1:0] label_in, input logic last_in);
      if (send_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_score   <= score_in;
      req_label   <= label_in;
      req_is_last <= last_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      rank_detection(score_in, label_in, last_in);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (ranked_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_landmarks(input logic [LMK_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      lmk_per_item = value;
      csr_writes++;
   endtask

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return SCORE_W'(16'h4000 + $urandom_range(0, 3));
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_list(input int len);
      for (int i = 0; i < len; i++)
         send_detection(pick_score(), LABEL_W'($urandom_range(0, 1023)), i == len - 1);
   endtask

   task automatic report_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   task automatic check_ranked_result();
      ranked_detection_type e;
      if (ranked_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual index %0d score 0x%0h",
                  $time, rsp_orig_index, rsp_sorted_score);
         error_count++;
      end else begin
         e = ranked_q.pop_front();
         report_field("orig_index", e.orig_index, rsp_orig_index);
         report_field("sorted_score", e.score, rsp_sorted_score);
         report_field("sorted_label", e.label, rsp_sorted_label);
         report_field("landmark_base", e.base, rsp_landmark_base);
         report_field("overflow", e.overflow, rsp_overflow);
         report_field("last_out", e.last, rsp_last_out);
      end
      results_checked++;
   endtask

   // Result side: check each transfer, then decide ready for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_ranked_result();
         if (hold_off_request != 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic test_single_detection();
      send_detection('0, '0, 1'b1);
      send_detection('1, '1, 1'b1);
   endtask

   task automatic test_score_extremes();
      send_detection(16'h0001, 10'h3FF, 1'b0);
      send_detection(16'hFFFF, 10'h000, 1'b0);
      send_detection(16'h0000, 10'h2AA, 1'b0);
      send_detection(16'h8000, 10'h155, 1'b0);
      send_detection(16'hFFFF, 10'h3FF, 1'b0);
      send_detection(16'h7FFF, 10'h001, 1'b1);
   endtask

   task automatic test_equal_scores();
      // ties must keep arrival order
      for (int i = 0; i < 5; i++) send_detection(16'h1234, LABEL_W'(i), 1'b0);
      send_detection(16'h1234, 10'h200, 1'b1);
      // rising scores: every new one moves to the head
      for (int i = 0; i < 6; i++) send_detection(SCORE_W'(i * 16'h2000), LABEL_W'(i), i == 5);
   endtask

   task automatic test_landmark_config();
      write_landmarks(4'hF);
      send_random_list(8);
      write_landmarks(4'h0);
      send_random_list(5);
      write_landmarks(4'h7);
      send_random_list(6);
   endtask

   task automatic test_capacity_overflow();
      write_landmarks(4'hF);
      send_random_list(CAPACITY);
      // over capacity: the last one is dropped but still releases the list
      send_random_list(CAPACITY + 2);
      send_random_list(3);
   endtask

   task automatic test_backpressure_fill();
      hold_off_request = 300;
      send_random_list(16);
      send_random_list(24);
      send_random_list(2);
   endtask

   task automatic test_random_lists();
      int done;
      int len;
      done = 0;
      send_idle_en = 1'b1;
      rsp_idle_en  = 1'b1;
      while (done < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            1, 2, 3: len = $urandom_range(13, CAPACITY);
            default: len = $urandom_range(1, 12);
         endcase
         send_random_list(len);
         done += len;
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0:       write_landmarks('0);
               1:       write_landmarks('1);
               default: write_landmarks(LMK_W'($urandom));
            endcase
         end
      end
   endtask

   task automatic test_streaming_no_idle();
      wait_for_drain();
      send_idle_en = 1'b0;
      rsp_idle_en  = 1'b0;
      for (int i = 0; i < 6; i++) send_random_list($urandom_range(1, 10));
   endtask

   initial begin : main_seq
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_detection();
      test_score_extremes();
      test_equal_scores();
      test_landmark_config();
      test_capacity_overflow();
      test_backpressure_fill();
      test_random_lists();
      test_streaming_no_idle();
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (ranked_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, ranked_q.size());
         error_count++;
      end
      $display("Sent %0d detections in %0d lists (%0d over capacity), %0d landmark writes.",
               items_sent, lists_sent, overflow_lists, csr_writes);
      $display("Checked %0d sorted results, %0d errors.", results_checked, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
